[hdl/s20x_pkg.sv]
package s20x_pkg;

   localparam int WORDS = 16;
   localparam int WORD_W = 32;
   localparam int STEPS_PER_DROUND = 8;

   typedef logic [WORDS-1:0][WORD_W-1:0] block_type;

   typedef struct packed {
      logic out_vld;
      logic skid_vld;
   } obuf_stat_type;

   localparam logic [0:1][0:3][0:3][3:0] QR_IDX = '{
      // column round
      '{ '{4'd0, 4'd4, 4'd8, 4'd12},
         '{4'd5, 4'd9, 4'd13, 4'd1},
         '{4'd10, 4'd14, 4'd2, 4'd6},
         '{4'd15, 4'd3, 4'd7, 4'd11} },
      // row round
      '{ '{4'd0, 4'd1, 4'd2, 4'd3},
         '{4'd5, 4'd6, 4'd7, 4'd4},
         '{4'd10, 4'd11, 4'd8, 4'd9},
         '{4'd15, 4'd12, 4'd13, 4'd14} }
   };

   localparam logic [0:3][4:0] ROT_AMT = '{5'd7, 5'd9, 5'd13, 5'd18};

   function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
                                               input logic [4:0] n);
      logic [2*WORD_W-1:0] dbl;
      dbl = {v, v} << n;
      return dbl[2*WORD_W-1:WORD_W];
   endfunction

endpackage

[hdl/s20x_if.sv]
interface s20x_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] in_pair_0;
   logic [63:0] in_pair_1;
   logic [63:0] in_pair_2;
   logic [63:0] in_pair_3;
   logic [63:0] in_pair_4;
   logic [63:0] in_pair_5;
   logic [63:0] in_pair_6;
   logic [63:0] in_pair_7;

   modport source (output valid, in_pair_0, in_pair_1, in_pair_2, in_pair_3,
                   in_pair_4, in_pair_5, in_pair_6, in_pair_7, input ready);
   modport sink (input valid, in_pair_0, in_pair_1, in_pair_2, in_pair_3,
                 in_pair_4, in_pair_5, in_pair_6, in_pair_7, output ready);
endinterface

interface s20x_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] out_pair_0;
   logic [63:0] out_pair_1;
   logic [63:0] out_pair_2;
   logic [63:0] out_pair_3;
   logic [63:0] out_pair_4;
   logic [63:0] out_pair_5;
   logic [63:0] out_pair_6;
   logic [63:0] out_pair_7;

   modport source (output valid, out_pair_0, out_pair_1, out_pair_2, out_pair_3,
                   out_pair_4, out_pair_5, out_pair_6, out_pair_7, input ready);
   modport sink (input valid, out_pair_0, out_pair_1, out_pair_2, out_pair_3,
                 out_pair_4, out_pair_5, out_pair_6, out_pair_7, output ready);
endinterface

[hdl/s20x_qstep.sv]
module s20x_qstep #(
   parameter int STEP = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_vld,
   input  s20x_pkg::block_type in_words,
   input  s20x_pkg::block_type in_orig,
   output logic                out_vld,
   output s20x_pkg::block_type out_words,
   output s20x_pkg::block_type out_orig
);
   import s20x_pkg::*;

   // which half of the double round and which of the four quarter-round lines
   localparam int HALF = STEP / 4;
   localparam int SUB  = STEP % 4;
   localparam int TGT  = (SUB + 1) % 4;
   localparam int OPB  = (SUB + 3) % 4;

   logic      vld_ff;
   block_type words_ff;
   block_type words_in;
   block_type orig_ff;

   // one add-rotate-xor line of each of the four independent quarter rounds
   always_comb begin
      words_in = in_words;
      for (int q = 0; q < 4; q++) begin
         words_in[QR_IDX[HALF][q][TGT]] = in_words[QR_IDX[HALF][q][TGT]] ^
            rotl(in_words[QR_IDX[HALF][q][SUB]] + in_words[QR_IDX[HALF][q][OPB]],
                 ROT_AMT[SUB]);
      end
   end

   // stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= in_vld;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (en) begin
         words_ff <= words_in;
         orig_ff  <= in_orig;
      end
   end

   assign out_vld   = vld_ff;
   assign out_words = words_ff;
   assign out_orig  = orig_ff;

endmodule

[hdl/s20x_obuf.sv]
module s20x_obuf (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_vld,
   input  s20x_pkg::block_type     push_data,
   output logic                    en,
   output s20x_pkg::obuf_stat_type stat,
   s20x_rsp_if.source              rsp_ch
);
   import s20x_pkg::*;

   logic      out_vld_ff;
   logic      out_vld_in;
   logic      skid_vld_ff;
   logic      skid_vld_in;
   block_type out_data_ff;
   block_type out_data_in;
   block_type skid_data_ff;
   block_type skid_data_in;
   logic      push;
   logic      pop;

   // pipeline runs unless the skid entry is holding a beat
   assign en   = !skid_vld_ff;
   assign push = en && push_vld;
   assign pop  = out_vld_ff && rsp_ch.ready;

   // output register plus one skid entry
   always_comb begin
      out_vld_in   = out_vld_ff;
      skid_vld_in  = skid_vld_ff;
      out_data_in  = out_data_ff;
      skid_data_in = skid_data_ff;
      if (skid_vld_ff) begin
         if (pop) begin
            out_data_in = skid_data_ff;
            skid_vld_in = 1'b0;
         end
      end else if (out_vld_ff) begin
         if (push && pop) begin
            out_data_in = push_data;
         end else if (pop) begin
            out_vld_in = 1'b0;
         end else if (push) begin
            skid_data_in = push_data;
            skid_vld_in  = 1'b1;
         end
      end else if (push) begin
         out_data_in = push_data;
         out_vld_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   // result beat, low word of each pair first
   assign rsp_ch.valid      = out_vld_ff;
   assign rsp_ch.out_pair_0 = out_data_ff[1:0];
   assign rsp_ch.out_pair_1 = out_data_ff[3:2];
   assign rsp_ch.out_pair_2 = out_data_ff[5:4];
   assign rsp_ch.out_pair_3 = out_data_ff[7:6];
   assign rsp_ch.out_pair_4 = out_data_ff[9:8];
   assign rsp_ch.out_pair_5 = out_data_ff[11:10];
   assign rsp_ch.out_pair_6 = out_data_ff[13:12];
   assign rsp_ch.out_pair_7 = out_data_ff[15:14];

   assign stat.out_vld  = out_vld_ff;
   assign stat.skid_vld = skid_vld_ff;

endmodule

[hdl/salsa20_core_xor_feedforward.sv]
// datapath: a req beat passes the round stages and then the output register to rsp valid
// throughput: one block per cycle while the skid is empty; each stage does one add-rotate-xor
// line of the four parallel quarter rounds, so a double round spans eight stages
// stalls: an output register plus one skid entry; req ready drops only while the skid is full
// reset: synchronous, clears the stage valid bits and the output buffer flags
module salsa20_core_xor_feedforward #(
   parameter int DOUBLE_ROUNDS = 10
) (
   input logic        clock,
   input logic        reset,
   s20x_req_if.sink   req_ch,
   s20x_rsp_if.source rsp_ch
);
   import s20x_pkg::*;

   localparam int NSTAGE = DOUBLE_ROUNDS * STEPS_PER_DROUND;

   logic          en;
   obuf_stat_type stat;
   logic          stage_vld   [0:NSTAGE];
   block_type     stage_words [0:NSTAGE];
   block_type     stage_orig  [0:NSTAGE];
   block_type     fin_words;

   // input beat unpacked into sixteen words
   assign req_ch.ready   = en;
   assign stage_vld[0]   = req_ch.valid;
   assign stage_words[0] = {req_ch.in_pair_7, req_ch.in_pair_6, req_ch.in_pair_5,
                            req_ch.in_pair_4, req_ch.in_pair_3, req_ch.in_pair_2,
                            req_ch.in_pair_1, req_ch.in_pair_0};
   assign stage_orig[0]  = stage_words[0];

   // round pipeline
   for (genvar k = 0; k < NSTAGE; k++) begin : g_stage
      s20x_qstep #(
         .STEP (k % STEPS_PER_DROUND)
      ) u_qstep (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_vld    (stage_vld[k]),
         .in_words  (stage_words[k]),
         .in_orig   (stage_orig[k]),
         .out_vld   (stage_vld[k+1]),
         .out_words (stage_words[k+1]),
         .out_orig  (stage_orig[k+1])
      );
   end

   // xor feedforward with the original block
   assign fin_words = stage_words[NSTAGE] ^ stage_orig[NSTAGE];

   s20x_obuf u_obuf (
      .clock     (clock),
      .reset     (reset),
      .push_vld  (stage_vld[NSTAGE]),
      .push_data (fin_words),
      .en        (en),
      .stat      (stat),
      .rsp_ch    (rsp_ch)
   );

   // skid entry is only ever filled behind an occupied output register
   a_skid_behind_out : assert property (@(posedge clock) disable iff (reset)
      stat.skid_vld |-> stat.out_vld)
      else $error("skid entry full while output register empty");

   // a stalled pipeline keeps its last stage
   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(stage_vld[NSTAGE]) && $stable(fin_words))
      else $error("pipeline moved during a stall");

   // a beat taken while the skid is full drains the skid
   a_skid_drains : assert property (@(posedge clock) disable iff (reset)
      (stat.skid_vld && rsp_ch.ready) |=> !stat.skid_vld && stat.out_vld)
      else $error("skid entry not drained after output beat");

endmodule

[tb/sv/tb_top.sv]
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import s20x_pkg::*;

   localparam int DROUNDS = 10;
   localparam int PIPE_LATENCY = 8 * DROUNDS + 1;
   localparam int TAIL_CYCLES = PIPE_LATENCY + 20;
   localparam int WATCHDOG_LIMIT = 20 * (PIPE_LATENCY + 2 * 14);
   localparam int MAX_IDLE = 13;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [7:0][63:0] pair_set_type;

   logic clock;
   logic reset;

   s20x_req_if req_ch();
   s20x_rsp_if rsp_ch();

   salsa20_core_xor_feedforward #(.DOUBLE_ROUNDS(DROUNDS)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // keystream blocks predicted for accepted req beats, oldest first
   pair_set_type keystream_pending[$];
   int           error_count = 0;
   int           quiet_cycles = 0;
   bit           send_idle_on = 1'b0;
   bit           rsp_idle_on = 1'b0;

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // predictor: salsa core with xor feedforward
   function automatic word_type rol32(input word_type v, input int n);
      return (v << n) | (v >> (32 - n));
   endfunction

   function automatic block_type quarter_mix(input block_type w, input int a, input int b,
                                             input int c, input int d);
      w[b] = w[b] ^ rol32(word_type'(w[a] + w[d]), 7);
      w[c] = w[c] ^ rol32(word_type'(w[b] + w[a]), 9);
      w[d] = w[d] ^ rol32(word_type'(w[c] + w[b]), 13);
      w[a] = w[a] ^ rol32(word_type'(w[d] + w[c]), 18);
      return w;
   endfunction

   function automatic block_type salsa_xor_core(input block_type src);
      block_type w;
      w = src;
      for (int r = 0; r < DROUNDS; r++) begin
         // column round
         w = quarter_mix(w, 0, 4, 8, 12);
         w = quarter_mix(w, 5, 9, 13, 1);
         w = quarter_mix(w, 10, 14, 2, 6);
         w = quarter_mix(w, 15, 3, 7, 11);
         // row round
         w = quarter_mix(w, 0, 1, 2, 3);
         w = quarter_mix(w, 5, 6, 7, 4);
         w = quarter_mix(w, 10, 11, 8, 9);
         w = quarter_mix(w, 15, 12, 13, 14);
      end
      return w ^ src;
   endfunction

   // scoreboard: check rsp beats, then predict from req beats
   always @(posedge clock) begin : keystream_check
      pair_set_type got;
      pair_set_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = {rsp_ch.out_pair_7, rsp_ch.out_pair_6, rsp_ch.out_pair_5, rsp_ch.out_pair_4,
                rsp_ch.out_pair_3, rsp_ch.out_pair_2, rsp_ch.out_pair_1, rsp_ch.out_pair_0};
         if (keystream_pending.size() == 0) begin
            $display("%0t: rsp beat expected none actual %h", $time, got);
            error_count++;
         end else begin
            want = keystream_pending.pop_front();
            for (int k = 0; k < 8; k++) begin
               if (got[k] !== want[k]) begin
                  $display("%0t: out_pair_%0d expected %h actual %h", $time, k, want[k],
                           got[k]);
                  error_count++;
               end
            end
         end
      end
      if (!reset && req_ch.valid && req_ch.ready) begin
         keystream_pending.push_back(salsa_xor_core(
            {req_ch.in_pair_7, req_ch.in_pair_6, req_ch.in_pair_5, req_ch.in_pair_4,
             req_ch.in_pair_3, req_ch.in_pair_2, req_ch.in_pair_1, req_ch.in_pair_0}));
      end
   end

   // watchdog on cycles with no beat on either side
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // rsp side backpressure
   initial begin : rsp_backpressure
      int stall;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = rsp_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   // one req beat, with an optional idle gap in front
   task automatic send_block(input block_type blk);
      int gap;
      gap = send_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      {req_ch.in_pair_7, req_ch.in_pair_6, req_ch.in_pair_5, req_ch.in_pair_4,
       req_ch.in_pair_3, req_ch.in_pair_2, req_ch.in_pair_1, req_ch.in_pair_0} <= blk;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // hold off the sender until every pending block is back
   task automatic wait_all_returned();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (keystream_pending.size() != 0) @(posedge clock);
   endtask

   // full random words, or sparse words that are zero or have one bit set
   function automatic block_type rand_block(input bit sparse);
      block_type blk;
      for (int i = 0; i < WORDS; i++) begin
         if (sparse)
            blk[i] = ($urandom_range(0, 3) == 0) ? word_type'(1) << $urandom_range(0, 31) : '0;
         else
            blk[i] = $urandom;
      end
      return blk;
   endfunction

   // uniform and carry heavy word patterns, an index ramp and the sigma constants, back to back
   task automatic test_word_patterns();
      block_type blk;
      send_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      send_block('0);
      send_block('1);
      send_block(block_type'({WORDS{32'h5555_5555}}));
      send_block(block_type'({WORDS{32'hAAAA_AAAA}}));
      send_block(block_type'({WORDS{32'h8000_0000}}));
      send_block(block_type'({WORDS{32'h0000_0001}}));
      send_block(block_type'({WORDS{32'h7FFF_FFFF}}));
      send_block(block_type'({(WORDS / 2){32'h0000_0001, 32'hFFFF_FFFF}}));
      for (int i = 0; i < WORDS; i++) blk[i] = word_type'(i);
      send_block(blk);
      // sigma constants on the diagonal
      for (int i = 0; i < WORDS; i++) blk[i] = word_type'(i) * 32'h0101_0101;
      blk[0] = 32'h6170_7865;
      blk[5] = 32'h3320_646E;
      blk[10] = 32'h7962_2D32;
      blk[15] = 32'h6B20_6574;
      send_block(blk);
   endtask

   // one pair at all ones, the rest zero, with idling
   task automatic test_single_pair_extremes();
      block_type blk;
      send_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      for (int k = 0; k < 8; k++) begin
         blk = '0;
         blk[2 * k] = '1;
         blk[2 * k + 1] = '1;
         send_block(blk);
      end
   endtask

   // full rate stream with no idling on either side
   task automatic test_back_to_back();
      send_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      repeat (40) send_block(rand_block(1'b0));
   endtask

   // sender pauses until the pipeline has drained, then resumes
   task automatic test_drain_pause();
      send_idle_on = 1'b0;
      rsp_idle_on = 1'b1;
      repeat (10) send_block(rand_block(1'b0));
      wait_all_returned();
      repeat (10) send_block(rand_block(1'b0));
   endtask

   // random blocks with idling modes changing every few dozen beats
   task automatic test_random_traffic();
      for (int n = 0; n < 330; n++) begin
         if (n % 40 == 0) begin
            send_idle_on = ($urandom_range(0, 3) != 0);
            rsp_idle_on = ($urandom_range(0, 3) != 0);
         end
         send_block(rand_block($urandom_range(0, 3) == 0));
      end
   endtask

   // stimulus sequence and final verdict
   initial begin
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      {req_ch.in_pair_7, req_ch.in_pair_6, req_ch.in_pair_5, req_ch.in_pair_4,
       req_ch.in_pair_3, req_ch.in_pair_2, req_ch.in_pair_1, req_ch.in_pair_0} <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_word_patterns();
      test_single_pair_extremes();
      test_back_to_back();
      test_drain_pause();
      test_random_traffic();

      wait_all_returned();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (keystream_pending.size() != 0) begin
         $display("%0t: pending blocks expected 0 actual %0d", $time,
                  keystream_pending.size());
      end
      if (error_count == 0 && keystream_pending.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

[filelist.f]
hdl/s20x_pkg.sv
hdl/s20x_if.sv
hdl/s20x_qstep.sv
hdl/s20x_obuf.sv
hdl/salsa20_core_xor_feedforward.sv
tb/sv/tb_top.sv
